// ===== sv/ffcalc_pkg.sv =====
`default_nettype none
package ffcalc_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int OUT_WIDTH   = 32;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

   localparam logic [2:0] KEY_DIGIT  = 3'd0;
   localparam logic [2:0] KEY_CLEAR  = 3'd1;
   localparam logic [2:0] KEY_EQUALS = 3'd2;
   localparam logic [2:0] KEY_ADD    = 3'd3;
   localparam logic [2:0] KEY_DIVIDE = 3'd6;

   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;

   typedef struct packed {
      logic [2:0] opcode;
      logic [3:0] digit;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] shown_value;
      logic [2:0]                  operator_waiting;
   } rsp_type;

   typedef struct packed {
      logic load_key;
      logic alu;
      logic div_start;
      logic div_step;
      logic div_fix;
      logic apply;
   } dp_cmd_type;

   typedef struct packed {
      logic need_comb;
      logic pend_div;
      logic div_last;
   } dp_sts_type;

endpackage
`default_nettype wire

// ===== sv/four_function_calculator_keypad_unit.sv =====
`default_nettype none
// channel   valid       stall       payload
// key in    req_valid   req_stall   req_data  (req_type)
// result    rsp_valid   rsp_stall   rsp_data  (rsp_type)
//
// One key beat at a time. Every key passes through accept, decide and apply
// states, including add, subtract and multiply; a key that completes a
// pending divide also runs the one-bit-per-cycle restoring divider (32 steps
// plus sign fix) between decide and apply.
// Synchronous reset returns to zero entry, no operator, new number.
// A stalled result holds the next key's completion until it is taken.
module four_function_calculator_keypad_unit import ffcalc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   ffcalc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   ffcalc_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule
`default_nettype wire

// ===== sv/ffcalc_ctrl.sv =====
`default_nettype none
module ffcalc_ctrl import ffcalc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output dp_cmd_type      cmd,
   input  wire dp_sts_type sts
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DECIDE  = 3'd1;
   localparam logic [2:0] ST_DIV_RUN = 3'd2;
   localparam logic [2:0] ST_DIV_FIX = 3'd3;
   localparam logic [2:0] ST_APPLY   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_key = 1'b1;
               state_in     = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!sts.need_comb) begin
               state_in = ST_APPLY;
            end else if (sts.pend_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_RUN;
            end else begin
               cmd.alu  = 1'b1;
               state_in = ST_APPLY;
            end
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_DIV_FIX;
            end
         end
         ST_DIV_FIX: begin
            cmd.div_fix = 1'b1;
            state_in    = ST_APPLY;
         end
         ST_APPLY: begin
            if (out_free) begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.apply) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/ffcalc_dpath.sv =====
`default_nettype none
module ffcalc_dpath import ffcalc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req_data,
   output rsp_type         rsp_data,
   input  wire dp_cmd_type cmd,
   output dp_sts_type      sts
);

   localparam int W = VALUE_WIDTH;

   // architectural state
   logic [W-1:0] entry_ff, entry_in;
   logic [W-1:0] stored_ff, stored_in;
   logic [2:0]   pend_ff, pend_in;
   logic         newnum_ff, newnum_in;

   logic [2:0]   opcode_ff;
   logic [3:0]   digit_ff;
   logic [W-1:0] res_ff;
   rsp_type      rsp_ff;

   // divider
   logic [W-1:0]         rem_ff;
   logic [W-1:0]         quo_ff;
   logic [W-1:0]         dvs_ff;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic                 neg_ff;
   logic [W:0]           shifted;
   logic [W:0]           trial;

   logic         is_oper;
   logic [W-1:0] val;
   logic [W-1:0] mag_left;
   logic [W-1:0] mag_right;

   assign is_oper = opcode_ff inside {[KEY_ADD:KEY_DIVIDE]};

   always_comb begin
      sts.need_comb = (pend_ff != OP_NONE) &&
                      ((opcode_ff == KEY_EQUALS) || (is_oper && !newnum_ff));
      sts.pend_div  = (pend_ff == OP_DIV);
      sts.div_last  = (cnt_ff == CNT_WIDTH'(W - 1));
   end

   assign mag_left  = stored_ff[W-1] ? (W'(0) - stored_ff) : stored_ff;
   assign mag_right = entry_ff[W-1] ? (W'(0) - entry_ff) : entry_ff;
   assign shifted   = {rem_ff, quo_ff[W-1]};
   assign trial     = shifted - {1'b0, dvs_ff};
   assign val       = sts.need_comb ? res_ff : entry_ff;

   always_comb begin
      entry_in  = entry_ff;
      stored_in = stored_ff;
      pend_in   = pend_ff;
      newnum_in = newnum_ff;
      case (opcode_ff)
         KEY_DIGIT: begin
            if (newnum_ff) begin
               entry_in = W'(digit_ff);
            end else begin
               entry_in = (entry_ff << 3) + (entry_ff << 1) + W'(digit_ff);
            end
            newnum_in = 1'b0;
         end
         KEY_CLEAR: begin
            entry_in  = '0;
            stored_in = '0;
            pend_in   = OP_NONE;
            newnum_in = 1'b1;
         end
         KEY_EQUALS: begin
            entry_in  = val;
            pend_in   = OP_NONE;
            newnum_in = 1'b1;
         end
         default: begin
            if (is_oper) begin
               entry_in  = val;
               stored_in = val;
               pend_in   = 3'(opcode_ff - KEY_ADD + OP_ADD);
               newnum_in = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff  <= '0;
         stored_ff <= '0;
         pend_ff   <= OP_NONE;
         newnum_ff <= 1'b1;
      end else if (cmd.apply) begin
         entry_ff  <= entry_in;
         stored_ff <= stored_in;
         pend_ff   <= pend_in;
         newnum_ff <= newnum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         opcode_ff <= req_data.opcode;
         digit_ff  <= req_data.digit;
      end
      if (cmd.apply) begin
         rsp_ff.shown_value      <= OUT_WIDTH'(signed'(entry_in));
         rsp_ff.operator_waiting <= pend_in;
      end
      if (cmd.alu) begin
         case (pend_ff)
            OP_ADD:  res_ff <= stored_ff + entry_ff;
            OP_SUB:  res_ff <= stored_ff - entry_ff;
            OP_MUL:  res_ff <= stored_ff * entry_ff;
            default: res_ff <= entry_ff;
         endcase
      end
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= mag_left;
         dvs_ff <= mag_right;
         cnt_ff <= '0;
         neg_ff <= stored_ff[W-1] ^ entry_ff[W-1];
      end
      if (cmd.div_step) begin
         if (!trial[W]) begin
            rem_ff <= trial[W-1:0];
         end else begin
            rem_ff <= shifted[W-1:0];
         end
         quo_ff <= {quo_ff[W-2:0], ~trial[W]};
         cnt_ff <= cnt_ff + CNT_WIDTH'(1);
      end
      if (cmd.div_fix) begin
         if (entry_ff == '0) begin
            res_ff <= stored_ff;
         end else if (neg_ff) begin
            res_ff <= W'(0) - quo_ff;
         end else begin
            res_ff <= quo_ff;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire
